// ===== rtl/bgs_pkg.sv =====
// Shared types and constants for the block Gauss-Seidel sweep engine.
// Holds the command/status structs between controller and datapath, and the state and mode codes.
// No dependencies.
`default_nettype none

package bgs_pkg;

    localparam int DEF_MAX_NODES    = 1024;
    localparam int DEF_MAX_NONZEROS = 8192;
    localparam int DEF_MAX_BLOCK    = 4;
    localparam int DEF_VALUE_BITS   = 32;

    // Field widths of the command and status structs; wide enough for the largest parameters
    localparam int ROW_FW = 17;
    localparam int K_FW   = 21;

    // Lanes of the residual vector (largest block size)
    localparam int LANES = 4;

    localparam logic [1:0] CFG_BLOCK_SIZE  = 2'd0;
    localparam logic [1:0] CFG_NODE_COUNT  = 2'd1;
    localparam logic [1:0] CFG_SWEEP_COUNT = 2'd2;
    localparam logic [1:0] CFG_SYMMETRIC   = 2'd3;

    typedef enum logic [2:0] {
        MODE_ROW_START = 3'd0,
        MODE_COLUMN    = 3'd1,
        MODE_BLOCK     = 3'd2,
        MODE_INV_DIAG  = 3'd3,
        MODE_RHS       = 3'd4,
        MODE_SOLUTION  = 3'd5,
        MODE_RUN       = 3'd6,
        MODE_READ      = 3'd7
    } mode_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_CLEAR,
        OP_LOAD,
        OP_RD_ISSUE,
        OP_RD_TAKE,
        OP_DONE,
        OP_BEG_ISSUE,
        OP_END_ISSUE,
        OP_END_TAKE,
        OP_RHS_ISSUE,
        OP_RHS_TAKE,
        OP_COL_ISSUE,
        OP_COL_TAKE,
        OP_MAC_ISSUE,
        OP_MAC_MUL,
        OP_MAC_SUB,
        OP_INV_ISSUE,
        OP_INV_MUL,
        OP_INV_ADD,
        OP_WB
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_TAKE,
        ST_RUN_START,
        ST_BEG_ISSUE,
        ST_END_ISSUE,
        ST_END_TAKE,
        ST_RHS_ISSUE,
        ST_RHS_TAKE,
        ST_K_CHECK,
        ST_COL_ISSUE,
        ST_COL_TAKE,
        ST_COL_CHECK,
        ST_MAC_ISSUE,
        ST_MAC_MUL,
        ST_MAC_SUB,
        ST_INV_ISSUE,
        ST_INV_MUL,
        ST_INV_ADD,
        ST_WB,
        ST_DONE
    } ctl_state_t;

    typedef struct packed {
        dp_op_t            op;
        logic [ROW_FW-1:0] row;
        logic [K_FW-1:0]   k;
        logic [1:0]        d1;
        logic [1:0]        d2;
        logic [2:0]        bs;
    } dp_cmd_t;

    typedef struct packed {
        logic [K_FW-1:0] beg;
        logic [K_FW-1:0] fin;
        logic            col_skip;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/bgs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/bgs_ctrl.sv =====
// Controller of the sweep engine: configuration registers, solution clearing pass,
// item handshake and the row / nonzero / block-element sequencing. Uses bgs_pkg.
`default_nettype none

module bgs_ctrl
    import bgs_pkg::*;
#(
    parameter int MAX_NODES    = DEF_MAX_NODES,
    parameter int MAX_NONZEROS = DEF_MAX_NONZEROS,
    parameter int MAX_BLOCK    = DEF_MAX_BLOCK
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  mode,
    output logic             out_valid,
    input  wire logic        out_ready,
    output dp_cmd_t          cmd,
    input  wire dp_stat_t    stat
);

    localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int RS_AW  = $clog2(MAX_NODES + 1);
    localparam int KW     = $clog2(MAX_NONZEROS + 1);
    localparam int CLR_W  = NODE_W + 2;

    ctl_state_t state_reg, state_next;

    logic [2:0]        bs_cfg_reg;
    logic [10:0]       nodes_cfg_reg;
    logic [15:0]       sweeps_cfg_reg;
    logic              sym_cfg_reg;

    logic [15:0]       sweep_reg, sweep_next;
    logic              back_reg, back_next;
    logic [NODE_W-1:0] row_reg, row_next;
    logic [KW-1:0]     k_reg, k_next;
    logic [1:0]        d1_reg, d1_next;
    logic [1:0]        d2_reg, d2_next;
    logic [CLR_W-1:0]  clr_reg, clr_next;
    logic              out_valid_reg, out_valid_next;

    logic [2:0]        bs_eff;
    logic [1:0]        bs_last;
    logic [RS_AW-1:0]  n_eff;
    logic [NODE_W-1:0] row_last;
    logic              accept;
    logic              sweep_end;

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        if (bs_cfg_reg == 3'd0)
        begin
            bs_eff = 3'd1;
        end
        else if (32'(bs_cfg_reg) > MAX_BLOCK)
        begin
            bs_eff = 3'(MAX_BLOCK);
        end
        else
        begin
            bs_eff = bs_cfg_reg;
        end
        bs_last = 2'(bs_eff - 3'd1);
        if (32'(nodes_cfg_reg) > MAX_NODES)
        begin
            n_eff = RS_AW'(MAX_NODES);
        end
        else
        begin
            n_eff = RS_AW'(nodes_cfg_reg);
        end
        row_last = NODE_W'(n_eff - RS_AW'(1));
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bs_cfg_reg     <= 3'd1;
            nodes_cfg_reg  <= 11'd0;
            sweeps_cfg_reg <= 16'd1;
            sym_cfg_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BLOCK_SIZE:  bs_cfg_reg     <= cfg_wdata[2:0];
                CFG_NODE_COUNT:  nodes_cfg_reg  <= cfg_wdata[10:0];
                CFG_SWEEP_COUNT: sweeps_cfg_reg <= cfg_wdata;
                CFG_SYMMETRIC:   sym_cfg_reg    <= cfg_wdata[0];
                default:         sym_cfg_reg    <= sym_cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            sweep_reg     <= '0;
            back_reg      <= 1'b0;
            row_reg       <= '0;
            k_reg         <= '0;
            d1_reg        <= '0;
            d2_reg        <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            back_reg      <= back_next;
            row_reg       <= row_next;
            k_reg         <= k_next;
            d1_reg        <= d1_next;
            d2_reg        <= d2_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign sweep_end = (17'(sweep_reg) + 17'd1) == 17'(sweeps_cfg_reg);

    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        back_next      = back_reg;
        row_next       = row_reg;
        k_next         = k_reg;
        d1_next        = d1_reg;
        d2_next        = d2_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        cmd.op  = OP_NOP;
        cmd.row = ROW_FW'(row_reg);
        cmd.k   = K_FW'(k_reg);
        cmd.d1  = d1_reg;
        cmd.d2  = d2_reg;
        cmd.bs  = bs_eff;

        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.op   = OP_CLEAR;
                cmd.row  = ROW_FW'(clr_reg[CLR_W-1:2]);
                cmd.d1   = clr_reg[1:0];
                clr_next = clr_reg + CLR_W'(1);
                if (&clr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode_t'(mode))
                        MODE_RUN:  state_next = ST_RUN_START;
                        MODE_READ:
                        begin
                            cmd.op     = OP_RD_ISSUE;
                            state_next = ST_READ_TAKE;
                        end
                        default:   cmd.op = OP_LOAD;
                    endcase
                end
            end
            ST_READ_TAKE:
            begin
                cmd.op         = OP_RD_TAKE;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_RUN_START:
            begin
                sweep_next = '0;
                back_next  = 1'b0;
                row_next   = '0;
                if (sweeps_cfg_reg == 16'd0 || n_eff == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_BEG_ISSUE;
                end
            end
            ST_BEG_ISSUE:
            begin
                cmd.op     = OP_BEG_ISSUE;
                state_next = ST_END_ISSUE;
            end
            ST_END_ISSUE:
            begin
                cmd.op     = OP_END_ISSUE;
                state_next = ST_END_TAKE;
            end
            ST_END_TAKE:
            begin
                cmd.op     = OP_END_TAKE;
                d1_next    = '0;
                state_next = ST_RHS_ISSUE;
            end
            ST_RHS_ISSUE:
            begin
                cmd.op     = OP_RHS_ISSUE;
                state_next = ST_RHS_TAKE;
            end
            ST_RHS_TAKE:
            begin
                cmd.op = OP_RHS_TAKE;
                if (d1_reg == bs_last)
                begin
                    k_next     = KW'(stat.beg);
                    state_next = ST_K_CHECK;
                end
                else
                begin
                    d1_next    = d1_reg + 2'd1;
                    state_next = ST_RHS_ISSUE;
                end
            end
            ST_K_CHECK:
            begin
                d1_next = '0;
                d2_next = '0;
                if (k_reg < KW'(stat.fin))
                begin
                    state_next = ST_COL_ISSUE;
                end
                else
                begin
                    state_next = ST_INV_ISSUE;
                end
            end
            ST_COL_ISSUE:
            begin
                cmd.op     = OP_COL_ISSUE;
                state_next = ST_COL_TAKE;
            end
            ST_COL_TAKE:
            begin
                cmd.op     = OP_COL_TAKE;
                state_next = ST_COL_CHECK;
            end
            ST_COL_CHECK:
            begin
                if (stat.col_skip)
                begin
                    k_next     = k_reg + KW'(1);
                    state_next = ST_K_CHECK;
                end
                else
                begin
                    state_next = ST_MAC_ISSUE;
                end
            end
            ST_MAC_ISSUE:
            begin
                cmd.op     = OP_MAC_ISSUE;
                state_next = ST_MAC_MUL;
            end
            ST_MAC_MUL:
            begin
                cmd.op     = OP_MAC_MUL;
                state_next = ST_MAC_SUB;
            end
            ST_MAC_SUB:
            begin
                cmd.op     = OP_MAC_SUB;
                state_next = ST_MAC_ISSUE;
                if (d2_reg == bs_last)
                begin
                    d2_next = '0;
                    if (d1_reg == bs_last)
                    begin
                        d1_next    = '0;
                        k_next     = k_reg + KW'(1);
                        state_next = ST_K_CHECK;
                    end
                    else
                    begin
                        d1_next = d1_reg + 2'd1;
                    end
                end
                else
                begin
                    d2_next = d2_reg + 2'd1;
                end
            end
            ST_INV_ISSUE:
            begin
                cmd.op     = OP_INV_ISSUE;
                state_next = ST_INV_MUL;
            end
            ST_INV_MUL:
            begin
                cmd.op     = OP_INV_MUL;
                state_next = ST_INV_ADD;
            end
            ST_INV_ADD:
            begin
                cmd.op = OP_INV_ADD;
                if (d2_reg == bs_last)
                begin
                    state_next = ST_WB;
                end
                else
                begin
                    d2_next    = d2_reg + 2'd1;
                    state_next = ST_INV_ISSUE;
                end
            end
            ST_WB:
            begin
                cmd.op  = OP_WB;
                d2_next = '0;
                if (d1_reg != bs_last)
                begin
                    d1_next    = d1_reg + 2'd1;
                    state_next = ST_INV_ISSUE;
                end
                else
                begin
                    state_next = ST_BEG_ISSUE;
                    if (!back_reg)
                    begin
                        if (row_reg != row_last)
                        begin
                            row_next = row_reg + NODE_W'(1);
                        end
                        else if (sym_cfg_reg)
                        begin
                            // backward pass starts on the last row again
                            back_next = 1'b1;
                        end
                        else if (sweep_end)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            sweep_next = sweep_reg + 16'd1;
                            row_next   = '0;
                        end
                    end
                    else if (row_reg != '0)
                    begin
                        row_next = row_reg - NODE_W'(1);
                    end
                    else if (sweep_end)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        sweep_next = sweep_reg + 16'd1;
                        back_next  = 1'b0;
                        row_next   = '0;
                    end
                end
            end
            ST_DONE:
            begin
                cmd.op         = OP_DONE;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/bgs_dp.sv =====
// Datapath of the sweep engine: matrix and vector memories, residual lanes,
// one shared multiplier, saturating adder and the result register. Uses bgs_pkg, bgs_ram.
`default_nettype none

module bgs_dp
    import bgs_pkg::*;
#(
    parameter int MAX_NODES    = DEF_MAX_NODES,
    parameter int MAX_NONZEROS = DEF_MAX_NONZEROS,
    parameter int MAX_BLOCK    = DEF_MAX_BLOCK,
    parameter int VALUE_BITS   = DEF_VALUE_BITS
) (
    input  wire logic               clk,
    input  wire dp_cmd_t            cmd,
    output dp_stat_t                stat,
    input  wire logic [2:0]         mode,
    input  wire logic [12:0]        position,
    input  wire logic [3:0]         component,
    input  wire logic signed [31:0] data,
    output logic signed [31:0]      value,
    output logic [9:0]              position_res,
    output logic [1:0]              component_res,
    output logic                    done_res
);

    localparam int VAL_W  = (VALUE_BITS > 32) ? 32 : VALUE_BITS;
    localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NZ_W   = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
    localparam int RS_AW  = $clog2(MAX_NODES + 1);
    localparam int KW     = $clog2(MAX_NONZEROS + 1);
    localparam int PW     = 2 * VAL_W;
    localparam int QW     = PW - 16;
    localparam int DW     = QW + 2;
    localparam logic signed [DW-1:0] SAT_HI = DW'((64'sd1 <<< (VAL_W - 1)) - 64'sd1);
    localparam logic signed [DW-1:0] SAT_LO = -SAT_HI - DW'(1);

    logic load_en;
    logic node_ok, nz_ok, vec_ok, blk_ok;
    logic [NODE_W-1:0] pos_node, row_node;
    logic [3:0] blk_idx;

    logic [13:0]             rs_rd;
    logic [9:0]              ci_rd;
    logic [VAL_W-1:0]        be_rd, id_rd, rhs_rd, sol_rd;
    logic                    sol_we;
    logic [NODE_W+1:0]       sol_waddr, sol_raddr;
    logic [VAL_W-1:0]        sol_wdata;

    logic [KW-1:0]           beg_reg, fin_reg;
    logic [9:0]              col_reg;
    logic signed [VAL_W-1:0] r_reg [LANES];
    logic signed [VAL_W-1:0] acc_reg;
    logic signed [PW-1:0]    prod_reg;
    logic [9:0]              rd_pos_reg;
    logic [1:0]              rd_comp_reg;
    logic                    rd_ok_reg;

    logic [1:0]              r_idx;
    logic signed [VAL_W-1:0] r_cur, mul_a, mul_b, acc_base, sum_sat;
    logic signed [QW-1:0]    q;
    logic signed [DW-1:0]    opnd_a, opnd_b, sum;

    assign load_en  = (cmd.op == OP_LOAD);
    assign node_ok  = 32'(position) < MAX_NODES;
    assign nz_ok    = 32'(position) < MAX_NONZEROS;
    assign vec_ok   = 32'(component) < MAX_BLOCK;
    assign blk_ok   = 32'(component) < MAX_BLOCK * MAX_BLOCK;
    assign pos_node = NODE_W'(position);
    assign row_node = cmd.row[NODE_W-1:0];
    assign blk_idx  = 4'({2'b00, cmd.d1} * {1'b0, cmd.bs}) + 4'(cmd.d2);

    bgs_ram #(.WIDTH(14), .DEPTH(MAX_NODES + 1)) u_row_start (
        .clk   (clk),
        .we    (load_en && mode_t'(mode) == MODE_ROW_START && 32'(position) <= MAX_NODES),
        .waddr (RS_AW'(position)),
        .wdata (data[13:0]),
        .raddr ((cmd.op == OP_END_ISSUE) ? RS_AW'(row_node) + RS_AW'(1) : RS_AW'(row_node)),
        .rdata (rs_rd)
    );

    bgs_ram #(.WIDTH(10), .DEPTH(1 << NZ_W)) u_column (
        .clk   (clk),
        .we    (load_en && mode_t'(mode) == MODE_COLUMN && nz_ok),
        .waddr (NZ_W'(position)),
        .wdata (data[9:0]),
        .raddr (cmd.k[NZ_W-1:0]),
        .rdata (ci_rd)
    );

    bgs_ram #(.WIDTH(VAL_W), .DEPTH(1 << (NZ_W + 4))) u_block (
        .clk   (clk),
        .we    (load_en && mode_t'(mode) == MODE_BLOCK && nz_ok && blk_ok),
        .waddr ({NZ_W'(position), component}),
        .wdata (data[VAL_W-1:0]),
        .raddr ({cmd.k[NZ_W-1:0], blk_idx}),
        .rdata (be_rd)
    );

    bgs_ram #(.WIDTH(VAL_W), .DEPTH(1 << (NODE_W + 4))) u_inv_diag (
        .clk   (clk),
        .we    (load_en && mode_t'(mode) == MODE_INV_DIAG && node_ok && blk_ok),
        .waddr ({pos_node, component}),
        .wdata (data[VAL_W-1:0]),
        .raddr ({row_node, blk_idx}),
        .rdata (id_rd)
    );

    bgs_ram #(.WIDTH(VAL_W), .DEPTH(1 << (NODE_W + 2))) u_rhs (
        .clk   (clk),
        .we    (load_en && mode_t'(mode) == MODE_RHS && node_ok && vec_ok),
        .waddr ({pos_node, component[1:0]}),
        .wdata (data[VAL_W-1:0]),
        .raddr ({row_node, cmd.d1}),
        .rdata (rhs_rd)
    );

    always_comb
    begin
        sol_we    = 1'b0;
        sol_waddr = {row_node, cmd.d1};
        sol_wdata = acc_reg;
        case (cmd.op)
            OP_LOAD:
            begin
                sol_we    = mode_t'(mode) == MODE_SOLUTION && node_ok && vec_ok;
                sol_waddr = {pos_node, component[1:0]};
                sol_wdata = data[VAL_W-1:0];
            end
            OP_CLEAR:
            begin
                sol_we    = 1'b1;
                sol_wdata = '0;
            end
            OP_WB:
            begin
                sol_we = 1'b1;
            end
            default:
            begin
                sol_we = 1'b0;
            end
        endcase
        if (cmd.op == OP_RD_ISSUE)
        begin
            sol_raddr = {pos_node, component[1:0]};
        end
        else
        begin
            sol_raddr = {NODE_W'(col_reg), cmd.d2};
        end
    end

    bgs_ram #(.WIDTH(VAL_W), .DEPTH(1 << (NODE_W + 2))) u_solution (
        .clk   (clk),
        .we    (sol_we),
        .waddr (sol_waddr),
        .wdata (sol_wdata),
        .raddr (sol_raddr),
        .rdata (sol_rd)
    );

    // Multiply operands and the shared saturating adder
    always_comb
    begin
        r_idx = (cmd.op == OP_INV_MUL) ? cmd.d2 : cmd.d1;
        r_cur = r_reg[r_idx];
        if (cmd.op == OP_MAC_MUL)
        begin
            mul_a = $signed(be_rd);
            mul_b = $signed(sol_rd);
        end
        else
        begin
            mul_a = $signed(id_rd);
            mul_b = r_cur;
        end
        // floor shift of the exact product
        q        = $signed(prod_reg[PW-1:16]);
        acc_base = (cmd.d2 == 2'd0) ? '0 : acc_reg;
        if (cmd.op == OP_MAC_SUB)
        begin
            opnd_a = DW'(r_cur);
            opnd_b = -DW'(q);
        end
        else
        begin
            opnd_a = DW'(acc_base);
            opnd_b = DW'(q);
        end
        sum = opnd_a + opnd_b;
        if (sum > SAT_HI)
        begin
            sum_sat = SAT_HI[VAL_W-1:0];
        end
        else if (sum < SAT_LO)
        begin
            sum_sat = SAT_LO[VAL_W-1:0];
        end
        else
        begin
            sum_sat = sum[VAL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_RD_ISSUE:
            begin
                rd_pos_reg  <= position[9:0];
                rd_comp_reg <= component[1:0];
                rd_ok_reg   <= node_ok && vec_ok;
            end
            OP_RD_TAKE:
            begin
                value         <= rd_ok_reg ? 32'($signed(sol_rd)) : 32'sd0;
                position_res  <= rd_pos_reg;
                component_res <= rd_comp_reg;
                done_res      <= 1'b0;
            end
            OP_DONE:
            begin
                value         <= 32'sd0;
                position_res  <= '0;
                component_res <= '0;
                done_res      <= 1'b1;
            end
            OP_END_ISSUE:
            begin
                beg_reg <= (32'(rs_rd) > MAX_NONZEROS) ? KW'(MAX_NONZEROS) : KW'(rs_rd);
            end
            OP_END_TAKE:
            begin
                fin_reg <= (32'(rs_rd) > MAX_NONZEROS) ? KW'(MAX_NONZEROS) : KW'(rs_rd);
            end
            OP_RHS_TAKE:
            begin
                r_reg[cmd.d1] <= $signed(rhs_rd);
            end
            OP_COL_TAKE:
            begin
                col_reg <= ci_rd;
            end
            OP_MAC_MUL, OP_INV_MUL:
            begin
                prod_reg <= mul_a * mul_b;
            end
            OP_MAC_SUB:
            begin
                r_reg[cmd.d1] <= sum_sat;
            end
            OP_INV_ADD:
            begin
                acc_reg <= sum_sat;
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign stat.beg      = K_FW'(beg_reg);
    assign stat.fin      = K_FW'(fin_reg);
    assign stat.col_skip = (32'(col_reg) >= MAX_NODES) || (32'(col_reg) == 32'(row_node));

endmodule

`default_nettype wire

// ===== rtl/block_gauss_seidel_sweep.sv =====
// Block Gauss-Seidel smoother over a block-CRS sparse matrix, Q16.16 fixed point.
// Top level: joins bgs_ctrl and bgs_dp. Uses bgs_pkg.
//
// After reset the block clears the solution memory, one entry a cycle, over
// 4 * 2**ceil(log2(MAX_NODES)) entries (4096 at the defaults), and takes no
// request until then. Load requests are written as they are accepted; a read
// request returns one result and no new request is taken until it is out.
// A run request returns one done result after all sweeps; each row reads its
// bounds and right-hand side, subtracts the off-diagonal block products and
// applies the inverse diagonal, with one multiplier and single-port reads.
`default_nettype none

module block_gauss_seidel_sweep
    import bgs_pkg::*;
#(
    parameter int MAX_NODES    = DEF_MAX_NODES,
    parameter int MAX_NONZEROS = DEF_MAX_NONZEROS,
    parameter int MAX_BLOCK    = DEF_MAX_BLOCK,
    parameter int VALUE_BITS   = DEF_VALUE_BITS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         mode,
    input  wire logic [12:0]        position,
    input  wire logic [3:0]         component,
    input  wire logic signed [31:0] data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      value,
    output logic [9:0]              position_res,
    output logic [1:0]              component_res,
    output logic                    done_res
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bgs_ctrl #(
        .MAX_NODES    (MAX_NODES),
        .MAX_NONZEROS (MAX_NONZEROS),
        .MAX_BLOCK    (MAX_BLOCK)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    bgs_dp #(
        .MAX_NODES    (MAX_NODES),
        .MAX_NONZEROS (MAX_NONZEROS),
        .MAX_BLOCK    (MAX_BLOCK),
        .VALUE_BITS   (VALUE_BITS)
    ) u_dp (
        .clk           (clk),
        .cmd           (cmd),
        .stat          (stat),
        .mode          (mode),
        .position      (position),
        .component     (component),
        .data          (data),
        .value         (value),
        .position_res  (position_res),
        .component_res (component_res),
        .done_res      (done_res)
    );

endmodule

`default_nettype wire
